FILE: src/stf_pkg.sv
`default_nettype none

package stf_pkg;

  // Field widths of the stream payloads.
  localparam int KIND_W     = 3;
  localparam int IDX_IN_W   = 6;
  localparam int VAL_IN_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int LEN_OUT_W  = 7;

  // Packed bus widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  // The empty marks are searched in groups of this many slots.
  localparam int GRP_SIZE = 8;
  localparam int OFF_W    = 3;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted request
    logic op;    // read the slot memory and build the group hit vector
    logic sel;   // pick the first group holding a free slot
    logic fin;   // commit the request and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_insert;  // the captured request is an insert
    logic out_free;   // the result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

FILE: src/slot_table_first_free.sv
`default_nettype none

// Channel   Direction  Bus                        Contents
// s_axis    in         tuser[2:0]                 kind
//                      tdata[39:0]                slot_index, new_value
// m_axis    out        tuser[1:0]                 status
//                      tdata[47:0]                slot_used, slot_value, length
//
// A request passes from its transfer through capture, memory read and group
// search, and commit, and its result is offered from the result register after
// commit; an insert adds a first-free group pick before commit, set by the
// grouped search over the empty marks. Reset marks every slot empty and clears
// the length; no clearing pass runs. A stalled result sits in the output
// register, and the engine waits at commit only while it is occupied.

module slot_table_first_free #(
  parameter int SLOTS      = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // slot_index [5:0], new_value [37:6], zero fill [39:38]
  input  wire logic [stf_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // kind [2:0]
  input  wire logic [stf_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // slot_used [5:0], slot_value [37:6], length [44:38], zero fill [47:45]
  output logic [stf_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // status [1:0]
  output logic [stf_pkg::STATUS_W-1:0]           m_axis_tuser
);

  stf_pkg::cmd_t cmd;
  stf_pkg::sts_t sts;

  logic [stf_pkg::SLOT_OUT_W-1:0] out_slot;
  logic [stf_pkg::VAL_IN_W-1:0]   out_value;
  logic [stf_pkg::LEN_OUT_W-1:0]  out_len;

  stf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stf_dp #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_kind_i    (s_axis_tuser),
    .in_idx_i     (s_axis_tdata[5:0]),
    .in_value_i   (s_axis_tdata[37:6]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_slot_o   (out_slot),
    .out_value_o  (out_value),
    .out_len_o    (out_len)
  );

  // Pack the result fields from the lowest bit up.
  assign m_axis_tdata = {3'b000, out_len, out_value, out_slot};

endmodule

`default_nettype wire

FILE: src/stf_ctrl.sv
`default_nettype none

module stf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire stf_pkg::sts_t sts_i,
  output stf_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OP   = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  // One request at a time: take it in idle, then walk it to commit.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_OP;
        end
      end
      ST_OP: begin
        cmd_o.op = 1'b1;
        state_d  = sts_i.is_insert ? ST_SEL : ST_FIN;
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/stf_dp.sv
`default_nettype none

module stf_dp #(
  parameter int SLOTS      = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire stf_pkg::cmd_t                    cmd_i,
  output stf_pkg::sts_t                         sts_o,
  input  wire logic [stf_pkg::KIND_W-1:0]       in_kind_i,
  input  wire logic [stf_pkg::IDX_IN_W-1:0]     in_idx_i,
  input  wire logic [stf_pkg::VAL_IN_W-1:0]     in_value_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [stf_pkg::STATUS_W-1:0]          out_status_o,
  output logic [stf_pkg::SLOT_OUT_W-1:0]        out_slot_o,
  output logic [stf_pkg::VAL_IN_W-1:0]          out_value_o,
  output logic [stf_pkg::LEN_OUT_W-1:0]         out_len_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;
  localparam int GRP_N = (SLOTS + stf_pkg::GRP_SIZE - 1) / stf_pkg::GRP_SIZE;
  localparam int GRP_W = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int PAD_N = GRP_N * stf_pkg::GRP_SIZE;
  localparam int VX_W  = (VALUE_BITS > stf_pkg::VAL_IN_W) ? VALUE_BITS : stf_pkg::VAL_IN_W;

  // Captured request.
  logic [stf_pkg::KIND_W-1:0]   req_kind_q;
  logic [stf_pkg::IDX_IN_W-1:0] req_idx_q;
  logic [stf_pkg::VAL_IN_W-1:0] req_value_q;

  // Table state.
  logic [VALUE_BITS-1:0] slot_mem_q [SLOTS];
  logic [VALUE_BITS-1:0] rd_data_q;
  logic [SLOTS-1:0]      empty_q, empty_d;
  logic [LEN_W-1:0]      len_q, len_d;

  // Free slot search.
  logic [SLOTS-1:0]               hit;
  logic [PAD_N-1:0]               hit_pad;
  logic [GRP_N-1:0]               grp_hit_d, grp_hit_q;
  logic [GRP_W-1:0]               grp_sel_d, grp_sel_q;
  logic                           found_d, found_q;
  logic [stf_pkg::GRP_SIZE-1:0]   grp_bits;
  logic [stf_pkg::OFF_W-1:0]      grp_off;

  // Request decode.
  logic [CMP_W-1:0] idx_ext, len_ext, last_slot, ins_slot;
  logic             in_range, full;
  logic [IDX_W-1:0] idx_addr, last_addr, rd_addr;
  logic [VX_W-1:0]  in_val_ext, out_val_ext;

  // Commit decisions.
  logic [stf_pkg::STATUS_W-1:0] res_status;
  logic [CMP_W-1:0]             res_slot;
  logic [VALUE_BITS-1:0]        res_value;
  logic                         wr_en, set_empty, clr_empty;
  logic [CMP_W-1:0]             wr_slot;
  logic [IDX_W-1:0]             wr_addr;

  // Result register.
  logic                          out_valid_q;
  logic [stf_pkg::STATUS_W-1:0]  out_status_q;
  logic [stf_pkg::SLOT_OUT_W-1:0] out_slot_q;
  logic [stf_pkg::VAL_IN_W-1:0]  out_value_q;
  logic [stf_pkg::LEN_OUT_W-1:0] out_len_q;

  assign idx_ext   = CMP_W'(req_idx_q);
  assign len_ext   = CMP_W'(len_q);
  assign last_slot = len_ext - CMP_W'(1);
  assign in_range  = idx_ext < len_ext;
  assign full      = len_ext == CMP_W'(SLOTS);
  assign idx_addr  = idx_ext[IDX_W-1:0];
  assign last_addr = last_slot[IDX_W-1:0];
  assign rd_addr   = (req_kind_q == stf_pkg::KIND_POP) ? last_addr : idx_addr;
  assign in_val_ext = VX_W'(req_value_q);

  assign sts_o.is_insert = req_kind_q == stf_pkg::KIND_INSERT;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Empty slots below the used length are the insert candidates.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = empty_q[i] && (CMP_W'(i) < len_ext);
    end
    hit_pad = PAD_N'(hit);
    for (int g = 0; g < GRP_N; g++) begin
      grp_hit_d[g] = |hit_pad[g*stf_pkg::GRP_SIZE +: stf_pkg::GRP_SIZE];
    end
  end

  // Lowest group that holds a candidate.
  always_comb begin
    grp_sel_d = '0;
    found_d   = 1'b0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        grp_sel_d = GRP_W'(g);
        found_d   = 1'b1;
      end
    end
  end

  // Lowest candidate inside the chosen group.
  always_comb begin
    grp_bits = hit_pad[grp_sel_q*stf_pkg::GRP_SIZE +: stf_pkg::GRP_SIZE];
    grp_off  = '0;
    for (int k = stf_pkg::GRP_SIZE - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        grp_off = stf_pkg::OFF_W'(k);
      end
    end
    ins_slot = CMP_W'({grp_sel_q, grp_off});
  end

  // Outcome of the captured request.
  always_comb begin
    res_status = stf_pkg::STATUS_NO_ENTRY;
    res_slot   = '0;
    res_value  = '0;
    wr_en      = 1'b0;
    set_empty  = 1'b0;
    clr_empty  = 1'b0;
    wr_slot    = len_ext;
    len_d      = len_q;
    unique case (req_kind_q)
      stf_pkg::KIND_GET: begin
        res_slot = idx_ext;
        if (in_range && !empty_q[idx_addr]) begin
          res_status = stf_pkg::STATUS_OK;
          res_value  = rd_data_q;
        end
      end
      stf_pkg::KIND_PUSH, stf_pkg::KIND_INSERT: begin
        if (req_kind_q == stf_pkg::KIND_INSERT && found_q) begin
          res_status = stf_pkg::STATUS_OK;
          res_slot   = ins_slot;
          wr_slot    = ins_slot;
          wr_en      = 1'b1;
          clr_empty  = 1'b1;
        end else if (full) begin
          res_status = stf_pkg::STATUS_FULL;
        end else begin
          res_status = stf_pkg::STATUS_OK;
          res_slot   = len_ext;
          wr_en      = 1'b1;
          clr_empty  = 1'b1;
          len_d      = len_q + LEN_W'(1);
        end
      end
      stf_pkg::KIND_REMOVE: begin
        res_slot = idx_ext;
        wr_slot  = idx_ext;
        if (in_range && !empty_q[idx_addr]) begin
          res_status = stf_pkg::STATUS_OK;
          res_value  = rd_data_q;
          set_empty  = 1'b1;
        end
      end
      stf_pkg::KIND_POP: begin
        if (len_q != '0) begin
          res_status = stf_pkg::STATUS_OK;
          res_slot   = last_slot;
          wr_slot    = last_slot;
          res_value  = empty_q[last_addr] ? '0 : rd_data_q;
          set_empty  = 1'b1;
          len_d      = last_slot[LEN_W-1:0];
        end
      end
      default: begin
        res_status = stf_pkg::STATUS_NO_ENTRY;
      end
    endcase
  end

  assign wr_addr     = wr_slot[IDX_W-1:0];
  assign out_val_ext = VX_W'(res_value);

  // Empty marks change only at commit.
  always_comb begin
    empty_d = empty_q;
    if (cmd_i.fin && clr_empty) begin
      empty_d[wr_addr] = 1'b0;
    end
    if (cmd_i.fin && set_empty) begin
      empty_d[wr_addr] = 1'b1;
    end
  end

  // Slot memory: one write at commit, one registered read in the op cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin && wr_en) begin
      slot_mem_q[wr_addr] <= in_val_ext[VALUE_BITS-1:0];
    end
    if (cmd_i.op) begin
      rd_data_q <= slot_mem_q[rd_addr];
    end
  end

  // Request capture, search registers and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_kind_q  <= in_kind_i;
      req_idx_q   <= in_idx_i;
      req_value_q <= in_value_i;
    end
    if (cmd_i.op) begin
      grp_hit_q <= grp_hit_d;
    end
    if (cmd_i.sel) begin
      grp_sel_q <= grp_sel_d;
      found_q   <= found_d;
    end else if (cmd_i.op) begin
      grp_sel_q <= '0;
      found_q   <= 1'b0;
    end
    if (cmd_i.fin) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot[stf_pkg::SLOT_OUT_W-1:0];
      out_value_q  <= out_val_ext[stf_pkg::VAL_IN_W-1:0];
      out_len_q    <= stf_pkg::LEN_OUT_W'(len_d);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q     <= '1;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      empty_q <= empty_d;
      if (cmd_i.fin) begin
        len_q <= len_d;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_value_o  = out_value_q;
  assign out_len_o    = out_len_q;

endmodule

`default_nettype wire

FILE: src/stf_checker.sv
`default_nettype none

module stf_checker #(
  parameter int SLOTS = 64
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [stf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [stf_pkg::STATUS_W-1:0]  m_axis_tuser
);

  logic [stf_pkg::LEN_OUT_W-1:0] prev_len_q;
  logic [stf_pkg::LEN_OUT_W-1:0] out_len;
  logic                          out_xfer;

  assign out_len  = m_axis_tdata[44:38];
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Length reported by the previous result transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_len_q <= '0;
    end else if (out_xfer) begin
      prev_len_q <= out_len;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // The engine is busy right after taking a request.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one is in work");

  // Each request moves the length by at most one.
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> out_len == prev_len_q
              || out_len == stf_pkg::LEN_OUT_W'(prev_len_q + 7'd1)
              || out_len == stf_pkg::LEN_OUT_W'(prev_len_q - 7'd1))
    else $error("length jumped by more than one");

  // A full refusal reports a full table.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == stf_pkg::STATUS_FULL
      |-> out_len == stf_pkg::LEN_OUT_W'(SLOTS))
    else $error("full status with a table that is not full");

endmodule

bind slot_table_first_free stf_checker #(.SLOTS(SLOTS)) u_stf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/slot_table_first_free_tb.sv
`timescale 1ns / 100ps

module slot_table_first_free_tb;

  localparam int SLOT_COUNT  = 64;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 150;
  localparam int DRAIN_WAIT  = 30;

  // Kind codes that the block does not implement.
  localparam logic [stf_pkg::KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [stf_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [stf_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_e;

  typedef struct packed {
    logic [stf_pkg::STATUS_W-1:0]   status;
    logic [stf_pkg::SLOT_OUT_W-1:0] slot;
    logic [stf_pkg::VAL_IN_W-1:0]   value;
    logic [stf_pkg::LEN_OUT_W-1:0]  length;
  } table_result_t;

  typedef struct packed {
    logic [stf_pkg::KIND_W-1:0]   kind;
    logic [stf_pkg::IDX_IN_W-1:0] idx;
    logic [stf_pkg::VAL_IN_W-1:0] val;
    logic                         typed;
    table_result_t                res;
  } directed_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [stf_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [stf_pkg::KIND_W-1:0]    s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [stf_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [stf_pkg::STATUS_W-1:0]  m_axis_tuser;

  // Shadow copy of the table, updated at each accepted transfer.
  logic [stf_pkg::VAL_IN_W-1:0] shadow_values [SLOT_COUNT];
  bit                           shadow_free [SLOT_COUNT];
  int                           shadow_len;

  table_result_t pending_results[$];
  int            err_count = 0;
  int            results_seen = 0;
  int            cycle_count = 0;
  bit            send_idle = 1'b1;
  bit            recv_idle = 1'b1;
  bit            hold_done = 1'b0;

  directed_row_t directed [24];

  slot_table_first_free dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("FAILURE");
    $finish;
  end

  // Append a value at the end of the table, refusing it when the table is full.
  function automatic table_result_t append_value(logic [stf_pkg::VAL_IN_W-1:0] val);
    table_result_t r;
    r = '0;
    if (shadow_len >= SLOT_COUNT) begin
      r.status = stf_pkg::STATUS_FULL;
    end else begin
      shadow_values[shadow_len] = val;
      shadow_free[shadow_len]   = 1'b0;
      r.status = stf_pkg::STATUS_OK;
      r.slot   = shadow_len[stf_pkg::SLOT_OUT_W-1:0];
      shadow_len++;
    end
    return r;
  endfunction

  // Apply one request to the shadow table and return the result it causes.
  function automatic table_result_t predict_table_op(logic [stf_pkg::KIND_W-1:0] kind,
                                                     logic [stf_pkg::IDX_IN_W-1:0] idx,
                                                     logic [stf_pkg::VAL_IN_W-1:0] val);
    table_result_t r;
    int hole;
    r = '0;
    r.status = stf_pkg::STATUS_NO_ENTRY;
    case (kind)
      stf_pkg::KIND_GET: begin
        r.slot = idx;
        if (idx < shadow_len && !shadow_free[idx]) begin
          r.status = stf_pkg::STATUS_OK;
          r.value  = shadow_values[idx];
        end
      end
      stf_pkg::KIND_PUSH: begin
        r = append_value(val);
      end
      stf_pkg::KIND_INSERT: begin
        hole = -1;
        for (int i = 0; i < shadow_len; i++) begin
          if (hole < 0 && shadow_free[i]) hole = i;
        end
        if (hole >= 0) begin
          shadow_values[hole] = val;
          shadow_free[hole]   = 1'b0;
          r.status = stf_pkg::STATUS_OK;
          r.slot   = hole[stf_pkg::SLOT_OUT_W-1:0];
        end else begin
          r = append_value(val);
        end
      end
      stf_pkg::KIND_REMOVE: begin
        r.slot = idx;
        if (idx < shadow_len && !shadow_free[idx]) begin
          shadow_free[idx] = 1'b1;
          r.status = stf_pkg::STATUS_OK;
          r.value  = shadow_values[idx];
        end
      end
      stf_pkg::KIND_POP: begin
        if (shadow_len > 0) begin
          shadow_len--;
          r.status = stf_pkg::STATUS_OK;
          r.slot   = shadow_len[stf_pkg::SLOT_OUT_W-1:0];
          r.value  = shadow_free[shadow_len] ? '0 : shadow_values[shadow_len];
          shadow_free[shadow_len] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.length = shadow_len[stf_pkg::LEN_OUT_W-1:0];
    return r;
  endfunction

  // Offer one request after a random gap and record its expected result.
  task automatic send_request(logic [stf_pkg::KIND_W-1:0] kind,
                              logic [stf_pkg::IDX_IN_W-1:0] idx,
                              logic [stf_pkg::VAL_IN_W-1:0] val, logic typed,
                              table_result_t typed_res);
    int gap;
    table_result_t r;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, idx};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_table_op(kind, idx, val);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Draw one random request, biased by the traffic mix of the current phase.
  task automatic draw_request(traffic_mix_e mix,
                              output logic [stf_pkg::KIND_W-1:0] kind,
                              output logic [stf_pkg::IDX_IN_W-1:0] idx,
                              output logic [stf_pkg::VAL_IN_W-1:0] val);
    int pick;
    int top;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (pick < 45)      kind = stf_pkg::KIND_PUSH;
        else if (pick < 85) kind = stf_pkg::KIND_INSERT;
        else if (pick < 92) kind = stf_pkg::KIND_GET;
        else if (pick < 96) kind = stf_pkg::KIND_REMOVE;
        else if (pick < 98) kind = stf_pkg::KIND_POP;
        else                kind = KIND_SPARE_5;
      end
      MIX_DRAIN: begin
        if (pick < 35)      kind = stf_pkg::KIND_POP;
        else if (pick < 70) kind = stf_pkg::KIND_REMOVE;
        else if (pick < 85) kind = stf_pkg::KIND_GET;
        else if (pick < 92) kind = stf_pkg::KIND_INSERT;
        else if (pick < 97) kind = stf_pkg::KIND_PUSH;
        else                kind = KIND_SPARE_5;
      end
      default: begin
        if (pick < 20)      kind = stf_pkg::KIND_GET;
        else if (pick < 40) kind = stf_pkg::KIND_PUSH;
        else if (pick < 60) kind = stf_pkg::KIND_INSERT;
        else if (pick < 80) kind = stf_pkg::KIND_REMOVE;
        else if (pick < 96) kind = stf_pkg::KIND_POP;
        else                kind = KIND_SPARE_5;
      end
    endcase
    if (kind == KIND_SPARE_5) begin
      case ($urandom_range(0, 2))
        0:       kind = KIND_SPARE_5;
        1:       kind = KIND_SPARE_6;
        default: kind = KIND_SPARE_7;
      endcase
    end
    // Most indexes land in or just past the used part of the table.
    top = (shadow_len > SLOT_COUNT - 1) ? SLOT_COUNT - 1 : shadow_len;
    if (shadow_len > 0 && $urandom_range(0, 9) < 7) begin
      idx = stf_pkg::IDX_IN_W'($urandom_range(0, top));
    end else begin
      idx = stf_pkg::IDX_IN_W'($urandom_range(0, SLOT_COUNT - 1));
    end
    case ($urandom_range(0, 15))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
  endtask

  // Result side: random back-pressure, one long hold-off, and checking.
  initial begin
    int gap;
    table_result_t got;
    table_result_t want;
    wait (rst_ni);
    forever begin
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = recv_idle ? $urandom_range(0, 17) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.status = m_axis_tuser;
      got.slot   = m_axis_tdata[5:0];
      got.value  = m_axis_tdata[37:6];
      got.length = m_axis_tdata[44:38];
      results_seen++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("Unexpected result transfer: status %0d slot %0d value %h length %0d",
                   got.status, got.slot, got.value, got.length);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.value !== want.value || got.length !== want.length) begin
          err_count++;
          if (err_count <= 10) begin
            $display("Result %0d mismatch: expected status %0d slot %0d value %h length %0d",
                     results_seen, want.status, want.slot, want.value, want.length);
            $display("  actual status %0d slot %0d value %h length %0d",
                     got.status, got.slot, got.value, got.length);
          end
        end
      end
    end
  end

  // Request side: reset, directed table, random phases, end of run.
  initial begin
    logic [stf_pkg::KIND_W-1:0]   kind;
    logic [stf_pkg::IDX_IN_W-1:0] idx;
    logic [stf_pkg::VAL_IN_W-1:0] val;
    traffic_mix_e                 mix;
    int                           sent;
    int                           phase_len;
    int                           phase;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      shadow_values[i] = '0;
      shadow_free[i]   = 1'b1;
    end
    shadow_len = 0;

    // Rows with a typed result were worked out by hand; the rest use the predictor.
    directed = '{
      // Everything misses on a table straight out of reset.
      '{stf_pkg::KIND_GET,    6'd0,  32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd0,  32'h0,        7'd0}},
      '{stf_pkg::KIND_POP,    6'd0,  32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd0,  32'h0,        7'd0}},
      '{stf_pkg::KIND_REMOVE, 6'd63, 32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd63, 32'h0,        7'd0}},
      '{KIND_SPARE_7,         6'd0,  32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd0,  32'h0,        7'd0}},
      '{KIND_SPARE_5,         6'd63, 32'hFFFFFFFF, 1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd0,  32'h0,        7'd0}},
      // Two pushes with extreme values.
      '{stf_pkg::KIND_PUSH,   6'd0,  32'hFFFFFFFF, 1'b1,
        '{stf_pkg::STATUS_OK,       6'd0,  32'h0,        7'd1}},
      '{stf_pkg::KIND_PUSH,   6'd63, 32'h0,        1'b1,
        '{stf_pkg::STATUS_OK,       6'd1,  32'h0,        7'd2}},
      '{stf_pkg::KIND_GET,    6'd0,  32'h0,        1'b1,
        '{stf_pkg::STATUS_OK,       6'd0,  32'hFFFFFFFF, 7'd2}},
      '{stf_pkg::KIND_GET,    6'd1,  32'h0,        1'b1,
        '{stf_pkg::STATUS_OK,       6'd1,  32'h0,        7'd2}},
      // Get past the length.
      '{stf_pkg::KIND_GET,    6'd2,  32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd2,  32'h0,        7'd2}},
      '{stf_pkg::KIND_GET,    6'd63, 32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd63, 32'h0,        7'd2}},
      // Remove, then get and remove the emptied slot.
      '{stf_pkg::KIND_REMOVE, 6'd0,  32'h0,        1'b1,
        '{stf_pkg::STATUS_OK,       6'd0,  32'hFFFFFFFF, 7'd2}},
      '{stf_pkg::KIND_GET,    6'd0,  32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd0,  32'h0,        7'd2}},
      '{stf_pkg::KIND_REMOVE, 6'd0,  32'h0,        1'b1,
        '{stf_pkg::STATUS_NO_ENTRY, 6'd0,  32'h0,        7'd2}},
      // Insert fills the hole first, then appends.
      '{stf_pkg::KIND_INSERT, 6'd5,  32'hA5A5A5A5, 1'b0, '0},
      '{stf_pkg::KIND_INSERT, 6'd0,  32'h5A5A5A5A, 1'b0, '0},
      '{stf_pkg::KIND_PUSH,   6'd0,  32'h12345678, 1'b0, '0},
      '{stf_pkg::KIND_REMOVE, 6'd3,  32'h0,        1'b0, '0},
      // Pop of a last slot that is already empty still shrinks the table.
      '{stf_pkg::KIND_POP,    6'd0,  32'h0,        1'b0, '0},
      '{KIND_SPARE_6,         6'd21, 32'h0F0F0F0F, 1'b0, '0},
      '{stf_pkg::KIND_POP,    6'd0,  32'h0,        1'b0, '0},
      '{stf_pkg::KIND_POP,    6'd0,  32'h0,        1'b0, '0},
      '{stf_pkg::KIND_POP,    6'd0,  32'h0,        1'b0, '0},
      '{stf_pkg::KIND_POP,    6'd0,  32'h0,        1'b0, '0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_request(directed[i].kind, directed[i].idx, directed[i].val,
                   directed[i].typed, directed[i].res);
    end
    wait_for_drain();

    // Random phases; the first one fills the table so that full refusals occur early.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        mix       = MIX_FILL;
        phase_len = 120;
      end else begin
        case ($urandom_range(0, 2))
          0:       mix = MIX_FILL;
          1:       mix = MIX_DRAIN;
          default: mix = MIX_BALANCED;
        endcase
        phase_len = $urandom_range(30, 120);
      end
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        draw_request(mix, kind, idx, val);
        send_request(kind, idx, val, 1'b0, '0);
        sent++;
      end
      wait_for_drain();
      phase++;
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
